// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on the next edge
`define ASSERT_NEXT(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
// implication checked on the same edge
`define ASSERT_SAME(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
`endif

// ===== rtl/hns_pkg.sv =====
// ----------------------------------------------------------------------------
// hns_pkg: shared types and constants for the hashed name set
// Request kinds, status codes, the queue entry type and key canonicalization.
// ----------------------------------------------------------------------------
package hns_pkg;
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [63:0] GOLDEN = 64'h9E37FFFFFFFC0001;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] hash;
  } hns_req_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_HEAD, BK_READ, BK_CMP, BK_UNLINK, BK_FREE, BK_OUT
  } bk_state_t;

  // clear every byte after the first zero byte
  function automatic logic [63:0] canon_key(input logic [63:0] k);
    logic [63:0] o;
    logic        stop;
    o = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) o[8*i +: 8] = k[8*i +: 8];
    end
    return o;
  endfunction
endpackage

// ===== rtl/hns_front.sv =====
// ----------------------------------------------------------------------------
// hns_front: request intake
// Canonicalizes the key and forms the product with the GOLDEN constant
// from four 16-bit partial products, then hands the request to the queue.
// ----------------------------------------------------------------------------
module hns_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [63:0]       in_key,
  output logic              q_valid,
  input  logic              q_full,
  output hns_pkg::hns_req_t q_data
);
  import hns_pkg::*;

  logic        busy_r, busy_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [1:0]  kind_r;
  logic [63:0] key_r;
  logic [63:0] acc_r;
  logic        done_r, done_nxt;
  logic [63:0] part;

  assign in_stall = busy_r;
  // key slice times constant, shifted into place, mod 2^64
  assign part = ({48'd0, key_r[16*step_r +: 16]} * GOLDEN) << (16 * step_r);
  assign q_valid = done_r;
  assign q_data  = '{kind: kind_r, key: key_r, hash: acc_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = done_r;
    if (in_valid && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      done_nxt = 1'b0;
    end else if (busy_r && !done_r) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) done_nxt = 1'b1;
    end else if (done_r && !q_full) begin
      done_nxt = 1'b0;
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy_r) begin
      kind_r <= in_kind;
      key_r  <= canon_key(in_key);
      acc_r  <= '0;
    end else if (busy_r && !done_r) begin
      acc_r <= acc_r + part;
    end
  end
endmodule

// ===== rtl/hns_queue.sv =====
// ----------------------------------------------------------------------------
// hns_queue: two-entry request queue
// Decouples the hashing front from the table engine.
// ----------------------------------------------------------------------------
module hns_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  hns_pkg::hns_req_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              empty,
  output hns_pkg::hns_req_t rd_data
);
  import hns_pkg::*;
  `include "assert_macros.svh"

  hns_req_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  `ASSERT_SAME(a_q_cnt, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue count overflow")
  `ASSERT_NEXT(a_q_wr, clk, rst_n, do_wr && !do_rd, cnt_r != 2'd0, "write lost")
  `ASSERT_NEXT(a_q_rd, clk, rst_n, do_rd && !do_wr, !full, "read lost")
endmodule

// ===== rtl/hns_back.sv =====
// ----------------------------------------------------------------------------
// hns_back: table engine
// Walks bucket chains in the node memories, links and unlinks nodes and
// drives the registered result.
// ----------------------------------------------------------------------------
module hns_back #(
  parameter int POOL_ENTRIES = 256,
  parameter int BUCKET_BITS  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  hns_pkg::hns_req_t q_data,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [8:0]        out_entry_count,
  output logic [5:0]        out_bucket
);
  import hns_pkg::*;
  `include "assert_macros.svh"

  localparam int NB  = 1 << BUCKET_BITS;
  localparam int PW  = $clog2(POOL_ENTRIES + 1);
  localparam int IW  = $clog2(POOL_ENTRIES);
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  logic [PW-1:0] head_r [NB];
  logic [NB-1:0] hvalid_r;
  logic [63:0]   nkey_m [POOL_ENTRIES];
  logic [PW-1:0] nnext_m [POOL_ENTRIES];

  bk_state_t state_r, state_nxt;
  hns_req_t  req_r;
  logic [BUCKET_BITS-1:0] b_r;
  logic [PW-1:0] cur_r, prev_r, free_r, fresh_r, live_r;
  logic [PW:0]   steps_r;
  logic [63:0]   rkey_r;
  logic [PW-1:0] rnext_r;
  logic [1:0]    stat_r;
  logic          ov_r;
  logic [1:0]    ost_r;
  logic [8:0]    ocnt_r;
  logic [5:0]    obk_r;
  logic [PW-1:0] hd_r;
  logic [BUCKET_BITS-1:0] bq;

  assign bq = q_data.hash[63 -: BUCKET_BITS];
  assign q_rd = (state_r == BK_IDLE) && !q_empty;
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_entry_count = ocnt_r;
  assign out_bucket = obk_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!q_empty) state_nxt = BK_HEAD;
      BK_HEAD:   state_nxt = (req_r.kind == KIND_INSERT) ? BK_OUT :
                             ((req_r.kind == KIND_FIND || req_r.kind == KIND_ERASE) &&
                              hd_r != NIL) ? BK_READ : BK_OUT;
      BK_READ:   state_nxt = BK_CMP;
      BK_CMP: begin
        if (rkey_r == req_r.key)
          state_nxt = (req_r.kind == KIND_ERASE) ? BK_UNLINK : BK_OUT;
        else if (rnext_r == NIL || steps_r + 1'b1 >= (PW+1)'(POOL_ENTRIES))
          state_nxt = BK_OUT;
        else
          state_nxt = BK_READ;
      end
      BK_UNLINK: state_nxt = BK_FREE;
      BK_FREE:   state_nxt = BK_OUT;
      BK_OUT:    if (!ov_r || !out_stall) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      hvalid_r <= '0;
      free_r   <= NIL;
      fresh_r  <= '0;
      live_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        BK_IDLE: ;
        BK_HEAD: begin
          if (req_r.kind == KIND_INSERT) begin
            if (free_r != NIL) begin
              free_r <= nnext_m[free_r[IW-1:0]];
              head_r[b_r] <= free_r;
              hvalid_r[b_r] <= 1'b1;
              live_r <= live_r + 1'b1;
            end else if (fresh_r != NIL) begin
              fresh_r <= fresh_r + 1'b1;
              head_r[b_r] <= fresh_r;
              hvalid_r[b_r] <= 1'b1;
              live_r <= live_r + 1'b1;
            end
          end
        end
        BK_FREE: begin
          free_r <= cur_r;
          if (live_r != '0) live_r <= live_r - 1'b1;
        end
        default: ;
      endcase
      if (state_r == BK_UNLINK && prev_r == NIL) head_r[b_r] <= rnext_r;
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    if (q_rd) begin
      req_r <= q_data;
      b_r   <= bq;
      hd_r  <= hvalid_r[bq] ? head_r[bq] : NIL;
    end
    unique case (state_r)
      BK_HEAD: begin
        cur_r   <= hd_r;
        prev_r  <= NIL;
        steps_r <= '0;
        if (req_r.kind == KIND_INSERT) begin
          stat_r <= (free_r != NIL || fresh_r != NIL) ? ST_DONE : ST_FULL;
          if (free_r != NIL) begin
            nkey_m[free_r[IW-1:0]]  <= req_r.key;
            nnext_m[free_r[IW-1:0]] <= hd_r;
          end else if (fresh_r != NIL) begin
            nkey_m[fresh_r[IW-1:0]]  <= req_r.key;
            nnext_m[fresh_r[IW-1:0]] <= hd_r;
          end
        end else begin
          stat_r <= ST_MISS;
        end
      end
      BK_READ: begin
        rkey_r  <= nkey_m[cur_r[IW-1:0]];
        rnext_r <= nnext_m[cur_r[IW-1:0]];
      end
      BK_CMP: begin
        if (rkey_r == req_r.key) stat_r <= ST_DONE;
        else begin
          prev_r  <= cur_r;
          cur_r   <= rnext_r;
          steps_r <= steps_r + 1'b1;
        end
      end
      BK_UNLINK: if (prev_r != NIL) nnext_m[prev_r[IW-1:0]] <= rnext_r;
      BK_FREE:   nnext_m[cur_r[IW-1:0]] <= free_r;
      BK_OUT: if (!ov_r || !out_stall) begin
        ost_r  <= stat_r;
        ocnt_r <= 9'(live_r);
        obk_r  <= 6'(b_r);
      end
      default: ;
    endcase
  end

  `ASSERT_SAME(a_live, clk, rst_n, 1'b1, live_r <= fresh_r, "live exceeds allocated")
  `ASSERT_NEXT(a_ins, clk, rst_n, state_r == BK_HEAD && req_r.kind == KIND_INSERT && (free_r != NIL || fresh_r != NIL), live_r == $past(live_r) + 1'b1, "insert count")
  `ASSERT_NEXT(a_out, clk, rst_n, ov_r && out_stall, ov_r && $stable({ost_r, ocnt_r, obk_r}), "out hold")
endmodule

// ===== rtl/hashed_name_set.sv =====
// ----------------------------------------------------------------------------
// hashed_name_set: chained hash set of 8-byte names
// Insert, find and erase with a fixed node pool and a live entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_kind (insert, find, erase)
//   and in_key. One transfer yields exactly one result transfer on
//   out_valid/out_stall with out_status, out_entry_count, out_bucket.
//   The front canonicalizes the key and builds the hash as the product with
//   the GOLDEN constant from four 16x64 multiplies; a two-entry queue feeds
//   the table engine. The engine steps insert, or a miss on an empty bucket,
//   through HEAD and OUT; find/erase add READ and CMP per chain node
//   visited, and erase adds UNLINK and FREE to unlink a found node. The
//   front takes no new request until it has handed the last one to the
//   queue, and the engine none until it has registered the last result.
//   Reset clears the bucket valid bits, free chain, pool fill count and
//   live count at once; node memories need no clearing.
//   A stalled result holds its value; the engine then waits, the queue
//   fills and in_stall rises.
// ----------------------------------------------------------------------------
module hashed_name_set #(
  parameter int POOL_ENTRIES = 256,
  parameter int BUCKET_BITS  = 6,
  parameter int KEY_BYTES    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [KEY_BYTES*8-1:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [8:0]  out_entry_count,
  output logic [5:0]  out_bucket
);
  import hns_pkg::*;

  hns_req_t fq_data, qb_data;
  logic     fq_valid, q_full, q_empty, q_rd;

  hns_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_key(64'(in_key)),
    .q_valid(fq_valid), .q_full, .q_data(fq_data)
  );

  hns_queue u_queue (
    .clk, .rst_n, .wr_en(fq_valid), .wr_data(fq_data), .full(q_full),
    .rd_en(q_rd), .empty(q_empty), .rd_data(qb_data)
  );

  hns_back #(.POOL_ENTRIES(POOL_ENTRIES), .BUCKET_BITS(BUCKET_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_data(qb_data), .q_rd, .out_valid, .out_stall,
    .out_status, .out_entry_count, .out_bucket
  );
endmodule
